// ----- rtl/core/ece_pkg.sv -----
// Shared types and codes for the epsilon-closure engine.
// No dependencies; imported by ece_front, ece_back and epsilon_closure_engine.
`timescale 1ns / 1ps

package ece_pkg;

    localparam int ECE_N_STATES = 32;   // default state count
    localparam int STATE_W      = 5;    // width of a state field
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;   // unused code, ignored

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MEMBER  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    // work kinds decided by the front end
    typedef enum logic [2:0] {
        OP_CLEAR,   // empty all edge lists
        OP_ADD,     // edge in range, may still hit a full list
        OP_DROP,    // edge out of range
        OP_QUERY,   // closure walk from an in-range start
        OP_LONE     // start out of range: single member, no walk
    } op_t;

    typedef struct packed {
        op_t                kind;
        logic [STATE_W-1:0] src_state;
        logic [STATE_W-1:0] dst_state;
        logic [STATE_W-1:0] root_state;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  member_state;
        logic                last;
    } res_t;

endpackage

// ----- rtl/core/ece_front.sv -----
// Front end: takes requests, classifies them and holds them in a two-entry queue.
// Depends on ece_pkg.
`timescale 1ns / 1ps

module ece_front
    import ece_pkg::*;
#(
    parameter int N_STATES = ECE_N_STATES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [STATE_W-1:0] src_state,
    input  logic [STATE_W-1:0] dst_state,
    input  logic [STATE_W-1:0] root_state,
    output logic               q_valid,
    output entry_t             q_entry,
    input  logic               q_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    entry_t            queue_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]   count_reg, count_next;

    entry_t            in_entry;
    logic              known_cmd;
    logic              push;

    always_comb
    begin
        in_entry.src_state  = src_state;
        in_entry.dst_state  = dst_state;
        in_entry.root_state = root_state;
        in_entry.kind       = OP_CLEAR;
        known_cmd           = 1'b1;
        case (cmd)
            CMD_CLEAR: in_entry.kind = OP_CLEAR;
            CMD_ADD:
            begin
                if (int'(src_state) >= N_STATES || int'(dst_state) >= N_STATES)
                    in_entry.kind = OP_DROP;
                else
                    in_entry.kind = OP_ADD;
            end
            CMD_QUERY:
            begin
                if (int'(root_state) >= N_STATES)
                    in_entry.kind = OP_LONE;
                else
                    in_entry.kind = OP_QUERY;
            end
            default: known_cmd = 1'b0;   // unused code: taken and discarded
        endcase
    end

    assign busy    = (count_reg == CNTW'(DEPTH));
    assign push    = start && !busy && known_cmd;
    assign q_valid = (count_reg != '0);
    assign q_entry = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNTW'(push) - CNTW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= in_entry;
    end

endmodule

// ----- rtl/core/ece_back.sv -----
// Back end: edge-list memory, per-state counts and the depth-first closure walk.
// Depends on ece_pkg.
`timescale 1ns / 1ps

module ece_back
    import ece_pkg::*;
#(
    parameter int N_STATES = ECE_N_STATES
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  entry_t q_entry,
    output logic   q_pop,
    output logic   res_valid,
    output res_t   res
);

    localparam int SW = $clog2(N_STATES);
    localparam int CW = $clog2(N_STATES + 1);
    localparam int AW = $clog2(N_STATES * N_STATES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_LOAD,
        S_SCAN,
        S_CHECK
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg [N_STATES];
    logic [CW-1:0]         count_next [N_STATES];
    logic [N_STATES-1:0]   visited_reg, visited_next;
    logic [CW-1:0]         sp_reg, sp_next;
    logic [SW-1:0]         u_reg, u_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [STATE_W-1:0]    pend_reg, pend_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    // memories
    logic [STATE_W-1:0]    edge_mem [N_STATES * N_STATES];
    logic [STATE_W-1:0]    edge_rd_reg;
    logic [STATE_W-1:0]    stack_mem [N_STATES];
    logic [STATE_W-1:0]    stack_rd_reg;

    logic                  edge_we;
    logic [AW-1:0]         edge_waddr, edge_raddr;
    logic                  stack_we;
    logic [SW-1:0]         stack_waddr, stack_raddr;
    logic [STATE_W-1:0]    stack_wdata;

    logic [SW-1:0]         from_idx, start_idx, pop_idx, v_idx, cnt_idx;
    logic [CW-1:0]         cnt_rd, sp_dec;
    logic                  v_new;

    assign from_idx  = SW'(q_entry.src_state);
    assign start_idx = SW'(q_entry.root_state);
    assign pop_idx   = SW'(stack_rd_reg);
    assign v_idx     = SW'(edge_rd_reg);
    assign cnt_idx   = (state_reg == S_IDLE) ? from_idx : pop_idx;
    assign cnt_rd    = count_reg[cnt_idx];
    assign sp_dec    = sp_reg - 1'b1;
    assign v_new     = (int'(edge_rd_reg) < N_STATES) && !visited_reg[v_idx];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        visited_next   = visited_reg;
        sp_next        = sp_reg;
        u_next         = u_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        q_pop          = 1'b0;
        edge_we        = 1'b0;
        edge_waddr     = AW'(int'(from_idx) * N_STATES + int'(cnt_rd));
        edge_raddr     = AW'(int'(u_reg) * N_STATES + int'(i_reg));
        stack_we       = 1'b0;
        stack_waddr    = sp_reg[SW-1:0];
        stack_wdata    = edge_rd_reg;
        stack_raddr    = sp_dec[SW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop                 = 1'b1;
                    res_valid_next        = 1'b1;
                    res_next.member_state = '0;
                    res_next.last         = 1'b1;
                    case (q_entry.kind)
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < N_STATES; k++)
                                count_next[k] = '0;
                            res_next.status = ST_CLEARED;
                        end
                        OP_ADD:
                        begin
                            if (int'(cnt_rd) >= N_STATES)
                                res_next.status = ST_DROPPED;
                            else
                            begin
                                edge_we              = 1'b1;
                                count_next[from_idx] = cnt_rd + 1'b1;
                                res_next.status      = ST_STORED;
                            end
                        end
                        OP_DROP: res_next.status = ST_DROPPED;
                        OP_LONE:
                        begin
                            res_next.status       = ST_MEMBER;
                            res_next.member_state = q_entry.root_state;
                        end
                        OP_QUERY:
                        begin
                            // start state is held back until we know if it is the last
                            res_valid_next          = 1'b0;
                            visited_next            = '0;
                            visited_next[start_idx] = 1'b1;
                            pend_next               = q_entry.root_state;
                            stack_we                = 1'b1;
                            stack_waddr             = '0;
                            stack_wdata             = q_entry.root_state;
                            sp_next                 = CW'(1);
                            state_next              = S_POP;
                        end
                        default: res_valid_next = 1'b0;
                    endcase
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    res_valid_next        = 1'b1;
                    res_next.status       = ST_MEMBER;
                    res_next.member_state = pend_reg;
                    res_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                u_next     = pop_idx;
                cnt_next   = cnt_rd;
                i_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (i_reg == cnt_reg)
                    state_next = S_POP;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (v_new)
                begin
                    visited_next[v_idx]   = 1'b1;
                    stack_we              = 1'b1;
                    sp_next               = sp_reg + 1'b1;
                    res_valid_next        = 1'b1;
                    res_next.status       = ST_MEMBER;
                    res_next.member_state = pend_reg;
                    res_next.last         = 1'b0;
                    pend_next             = edge_rd_reg;
                end
                state_next = S_SCAN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int k = 0; k < N_STATES; k++)
                count_reg[k] <= '0;
            visited_reg   <= '0;
            sp_reg        <= '0;
            u_reg         <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            pend_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            visited_reg   <= visited_next;
            sp_reg        <= sp_next;
            u_reg         <= u_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= q_entry.dst_state;
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/core/epsilon_closure_engine.sv -----
// With the engine idle, a clear or add request is first written into the request
// queue and its result is then registered in the back end. A query pops each state
// from the stack, reads its edge list one entry at a time and checks each target;
// this walk sets the throughput. Results cannot be stalled; busy rises only when
// the two-entry request queue is full. Reset clears edge counts, queue and walk
// state at once; the edge memory is not cleared, as only entries below a count are read.
`timescale 1ns / 1ps

module epsilon_closure_engine
    import ece_pkg::*;
#(
    parameter int N_STATES = ECE_N_STATES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [STATE_W-1:0]  src_state,
    input  logic [STATE_W-1:0]  dst_state,
    input  logic [STATE_W-1:0]  root_state,
    output logic                valid,
    output logic [STATUS_W-1:0] status,
    output logic [STATE_W-1:0]  member_state,
    output logic                last
);

    // Front end to back end: one classified request per pop.
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    // Registered result from the back end, shown for exactly one cycle.
    logic   res_valid;
    res_t   res;

    // The front end range-checks add and query requests so the back end only
    // has to look at list fullness, which depends on its own count state.
    ece_front #(
        .N_STATES (N_STATES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .src_state  (src_state),
        .dst_state  (dst_state),
        .root_state (root_state),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    // The back end runs the stack-based walk; each member is held one step so
    // that the final one can carry the last flag.
    ece_back #(
        .N_STATES (N_STATES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign valid        = res_valid;
    assign status       = res.status;
    assign member_state = res.member_state;
    assign last         = res.last;

`ifndef SYNTH
    // Only closure members may be followed by further results of the same request.
    a_last_non_member: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_MEMBER |-> last)
        else $error("non-member result without last flag");

    // The back end only takes a request that the queue holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A full queue always offers a request to the back end.
    a_busy_queue: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> q_valid)
        else $error("busy with empty queue");

    // Non-member results only follow a pop of the queue in the cycle before.
    a_single_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_MEMBER |-> $past(q_pop))
        else $error("command result without a queue pop");
`endif

endmodule
